[rtl/rrbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbm_pkg
// Shared widths, operation codes and the ROM bank mask table of the
// cartridge bank mapper.
// ----------------------------------------------------------------------------
package rrbm_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int OP_W        = 2;
   localparam int OFFSET_W    = 21;
   localparam int BANK_W      = 7;
   localparam int LOW_BANK_W  = 5;
   localparam int UPPER_W     = 2;
   localparam int ROM_SIZE_W  = 3;
   localparam int RAM_SIZE_W  = 2;
   localparam int CSR_DATA_W  = 3;
   localparam int BANK_BITS   = 14;   // 16 KB ROM bank

   localparam int REQ_DATA_W  = 24;   // address + data, byte aligned
   localparam int RSP_DATA_W  = 24;   // mapped offset, byte aligned

   // request operations
   localparam logic [OP_W-1:0] OP_REG_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_ROM_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_RAM_XLATE = 2'd2;

   // register write regions, address bits 14:13
   localparam logic [1:0] WR_RAM_ENABLE = 2'd0;
   localparam logic [1:0] WR_LOW_BANK   = 2'd1;
   localparam logic [1:0] WR_UPPER_BANK = 2'd2;
   localparam logic [1:0] WR_MODE       = 2'd3;

   // configuration register indexes
   localparam logic CSR_ROM_SIZE = 1'b0;
   localparam logic CSR_RAM_SIZE = 1'b1;

   // ram size codes
   localparam logic [RAM_SIZE_W-1:0] RAM_NONE = 2'd0;
   localparam logic [RAM_SIZE_W-1:0] RAM_2K   = 2'd1;

   localparam logic [3:0] RAM_KEY = 4'hA;

   function automatic logic [BANK_W-1:0] rom_bank_mask(input logic [ROM_SIZE_W-1:0] code);
      logic [BANK_W-1:0] m;
      case (code)
         3'd0:    m = 7'h01;
         3'd1:    m = 7'h03;
         3'd2:    m = 7'h07;
         3'd3:    m = 7'h0F;
         3'd4:    m = 7'h1F;
         3'd5:    m = 7'h3F;
         3'd6:    m = 7'h7F;
         default: m = 7'h7F;
      endcase
      return m;
   endfunction

endpackage

[rtl/rom_ram_bank_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_core
// Cartridge bank controller: bank register writes, ROM and RAM address
// translation into byte offsets of the ROM and RAM images.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tuser: op; tdata: address, data
//  rsp_    | out | tuser: hit; tdata: mapped_offset
//  csr_    | in  | we, index, wdata (write only)
//
//  a request is registered in the input stage, then translated and written
//  to the result register, from which rsp_ takes it.
//  one request per cycle while the result is not stalled; the translate
//  stage also updates the bank registers, in request order.
//  a stalled result holds both stages once they are full; only then does
//  req_tready follow rsp_tready.
//  synchronous reset clears the bank state to ROM mode, bank 1, RAM off.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_core
   import rrbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] address, [23:16] data
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [20:0] mapped_offset, [23:21] zero
   output logic                  rsp_tuser,   // [0] hit
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  s1_valid_ff;
   logic [OP_W-1:0]       s1_op_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [DATA_W-1:0]     s1_data_ff;

   logic                  out_valid_ff;
   logic [OFFSET_W-1:0]   out_offset_ff, out_offset_in;
   logic                  out_hit_ff, out_hit_in;

   logic [ROM_SIZE_W-1:0] rom_size_ff;
   logic [RAM_SIZE_W-1:0] ram_size_ff;
   logic [LOW_BANK_W-1:0] low_bank_ff, low_bank_in;
   logic [UPPER_W-1:0]    upper_bank_ff, upper_bank_in;
   logic                  ram_mode_ff, ram_mode_in;
   logic                  ram_en_ff, ram_en_in;

   logic                  advance;
   logic                  s1_fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   // translate stage
   always_comb begin
      logic [BANK_W-1:0]     full;
      logic [BANK_W-1:0]     mask;
      logic [BANK_W-1:0]     bank;
      logic [UPPER_W-1:0]    ram_bank;
      logic [LOW_BANK_W-1:0] low_val;
      full          = {upper_bank_ff, low_bank_ff};
      mask          = rom_bank_mask(rom_size_ff);
      bank          = '0;
      ram_bank      = ram_mode_ff ? upper_bank_ff : '0;
      low_val       = s1_data_ff[LOW_BANK_W-1:0];
      out_offset_in = '0;
      out_hit_in    = 1'b0;
      low_bank_in   = low_bank_ff;
      upper_bank_in = upper_bank_ff;
      ram_mode_in   = ram_mode_ff;
      ram_en_in     = ram_en_ff;
      case (s1_op_ff)
         OP_REG_WRITE: begin
            if (!s1_addr_ff[15]) begin
               out_hit_in = 1'b1;
               case (s1_addr_ff[14:13])
                  WR_RAM_ENABLE: ram_en_in     = (s1_data_ff[3:0] == RAM_KEY);
                  WR_LOW_BANK:   low_bank_in   = (low_val == '0) ?
                                                 LOW_BANK_W'(1) : low_val;
                  WR_UPPER_BANK: upper_bank_in = s1_data_ff[UPPER_W-1:0];
                  default:       ram_mode_in   = s1_data_ff[0];
               endcase
            end
         end
         OP_ROM_READ: begin
            if (!s1_addr_ff[15]) begin
               out_hit_in = 1'b1;
               if (!s1_addr_ff[14]) begin
                  // bank 0 space follows the upper bits only in RAM mode
                  bank = ram_mode_ff ? (full & mask & 7'h60) : '0;
               end else begin
                  bank = (ram_mode_ff ? {2'b00, low_bank_ff} : full) & mask;
               end
               out_offset_in = {bank, s1_addr_ff[BANK_BITS-1:0]};
            end
         end
         OP_RAM_XLATE: begin
            if (ram_en_ff && (ram_size_ff != RAM_NONE)) begin
               if (ram_size_ff == RAM_2K) begin
                  out_hit_in    = (s1_addr_ff[15:11] == '0);
                  out_offset_in = {8'd0, ram_bank, s1_addr_ff[10:0]};
               end else begin
                  out_hit_in    = (s1_addr_ff[15:13] == '0);
                  out_offset_in = {6'd0, ram_bank, s1_addr_ff[12:0]};
               end
               if (!out_hit_in) begin
                  out_offset_in = '0;
               end
            end
         end
         default: begin
            out_hit_in = 1'b0;
         end
      endcase
   end

   // control and bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         rom_size_ff   <= '0;
         ram_size_ff   <= '0;
         low_bank_ff   <= LOW_BANK_W'(1);
         upper_bank_ff <= '0;
         ram_mode_ff   <= 1'b0;
         ram_en_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            low_bank_ff   <= low_bank_in;
            upper_bank_ff <= upper_bank_in;
            ram_mode_ff   <= ram_mode_in;
            ram_en_ff     <= ram_en_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ROM_SIZE: rom_size_ff <= csr_wdata;
               CSR_RAM_SIZE: ram_size_ff <= csr_wdata[RAM_SIZE_W-1:0];
               default:      rom_size_ff <= rom_size_ff;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff   <= req_tuser;
         s1_addr_ff <= req_tdata[ADDR_W-1:0];
         s1_data_ff <= req_tdata[ADDR_W+DATA_W-1:ADDR_W];
      end
      if (s1_fire) begin
         out_offset_ff <= out_offset_in;
         out_hit_ff    <= out_hit_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-OFFSET_W)'(0), out_offset_ff};
   assign rsp_tuser  = out_hit_ff;

   a_low_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      low_bank_ff != '0)
      else $error("low bank register holds zero");

   a_miss_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> out_offset_ff == '0)
      else $error("miss carries a nonzero offset");

   a_stall_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("request lost in input stage during stall");

   a_state_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && s1_op_ff == OP_REG_WRITE) |=>
         $stable(low_bank_ff) && $stable(upper_bank_ff) && $stable(ram_mode_ff))
      else $error("bank state changed without a register write");

endmodule
